// File: sv/pbvd_pkg.sv
// shared types and constants for the protobuf varint field decoder
`default_nettype none

package pbvd_pkg;

    localparam int ACC_W                    = 64;
    localparam int FIELD_W                  = 61;
    localparam int VALUE_W                  = 32;
    localparam int CNT_W                    = 4;
    localparam int SHIFT_W                  = 6;
    localparam int STATUS_W                 = 3;
    localparam int BYTE_W                   = 8;
    localparam int GROUP_W                  = 7;
    localparam int WIRE_W                   = 3;
    localparam int S_TDATA_W                = 8;
    localparam int M_TDATA_W                = 96;
    localparam int M_TUSER_W                = 3;
    localparam int DEFAULT_MAX_VARINT_BYTES = 10;

    typedef enum logic [2:0] {
        PH_KEY     = 3'b001,
        PH_VALUE   = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_LONG     = 3'd2,
        ST_FIELD0   = 3'd3,
        ST_WIRETYPE = 3'd4
    } status_t;

    localparam logic [WIRE_W-1:0] WIRE_VARINT = 3'd0;

    typedef struct packed {
        phase_t             phase;
        logic [ACC_W-1:0]   acc;
        logic [CNT_W-1:0]   cnt;
        logic [FIELD_W-1:0] held;
    } dec_state_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        field_number;
        logic signed [VALUE_W-1:0] field_value;
        status_t                   status;
        logic                      last;
    } dec_result_t;

endpackage

`default_nettype wire

// File: sv/pbvd_in_stage.sv
// input register stage for incoming message bytes
`default_nettype none

module pbvd_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pbvd_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                           s_tlast,  // end_of_message
    input  wire logic                           advance,
    output pbvd_pkg::in_item_t                  item
);

    logic                        valid_reg;
    logic [pbvd_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[pbvd_pkg::BYTE_W-1:0];
            last_reg <= s_tlast;
        end
    end

    assign item.valid     = valid_reg;
    assign item.data_byte = byte_reg;
    assign item.last      = last_reg;

endmodule

`default_nettype wire

// File: sv/pbvd_step.sv
// single-pass decode of one byte against the current element state
`default_nettype none

module pbvd_step #(
    parameter int MAX_VARINT_BYTES = pbvd_pkg::DEFAULT_MAX_VARINT_BYTES
) (
    input  pbvd_pkg::dec_state_t              state,
    input  wire logic [pbvd_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         last,
    output pbvd_pkg::dec_state_t              state_next,
    output logic                              res_valid,
    output pbvd_pkg::dec_result_t             result
);

    logic [pbvd_pkg::SHIFT_W-1:0] shamt;
    logic [pbvd_pkg::ACC_W-1:0]   acc_n;
    logic [pbvd_pkg::CNT_W-1:0]   cnt_n;
    logic [pbvd_pkg::FIELD_W-1:0] fnum;
    logic                         more;
    logic                         fail;
    pbvd_pkg::status_t            fail_status;

    assign shamt = pbvd_pkg::SHIFT_W'({2'b00, state.cnt} * 6'd7);
    assign acc_n = state.acc
                 | ({{(pbvd_pkg::ACC_W-pbvd_pkg::GROUP_W){1'b0}},
                     data_byte[pbvd_pkg::GROUP_W-1:0]} << shamt);
    assign cnt_n = state.cnt + 1'b1;
    assign more  = data_byte[pbvd_pkg::BYTE_W-1];
    assign fnum  = acc_n[pbvd_pkg::ACC_W-1:pbvd_pkg::WIRE_W];

    always_comb begin
        state_next          = state;
        res_valid           = 1'b0;
        result.field_number = '0;
        result.field_value  = '0;
        result.status       = pbvd_pkg::ST_OK;
        result.last         = last;
        fail                = 1'b0;
        fail_status         = pbvd_pkg::ST_OK;

        if (state.phase == pbvd_pkg::PH_DISCARD) begin
            if (last) begin
                state_next.phase = pbvd_pkg::PH_KEY;
            end
        end else begin
            priority if (cnt_n >= pbvd_pkg::CNT_W'(MAX_VARINT_BYTES)) begin
                fail        = 1'b1;
                fail_status = pbvd_pkg::ST_LONG;
            end else if (more) begin
                if (last) begin
                    fail        = 1'b1;
                    fail_status = pbvd_pkg::ST_TRUNC;
                end else begin
                    state_next.acc = acc_n;
                    state_next.cnt = cnt_n;
                end
            end else if (state.phase != pbvd_pkg::PH_VALUE) begin
                // key complete
                priority if (fnum == '0) begin
                    fail        = 1'b1;
                    fail_status = pbvd_pkg::ST_FIELD0;
                end else if (acc_n[pbvd_pkg::WIRE_W-1:0] != pbvd_pkg::WIRE_VARINT) begin
                    fail        = 1'b1;
                    fail_status = pbvd_pkg::ST_WIRETYPE;
                end else if (last) begin
                    fail        = 1'b1;
                    fail_status = pbvd_pkg::ST_TRUNC;
                end else begin
                    state_next.held  = fnum;
                    state_next.acc   = '0;
                    state_next.cnt   = '0;
                    state_next.phase = pbvd_pkg::PH_VALUE;
                end
            end else begin
                // value complete
                res_valid           = 1'b1;
                result.field_number = state.held;
                result.field_value  = acc_n[pbvd_pkg::VALUE_W-1:0];
                state_next.acc      = '0;
                state_next.cnt      = '0;
                state_next.phase    = pbvd_pkg::PH_KEY;
            end

            if (fail) begin
                res_valid        = 1'b1;
                result.status    = fail_status;
                state_next.acc   = '0;
                state_next.cnt   = '0;
                state_next.phase = last ? pbvd_pkg::PH_KEY : pbvd_pkg::PH_DISCARD;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/pbvd_out_stage.sv
// result register stage driving the output channel
`default_nettype none

module pbvd_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire logic                            res_valid,
    input  pbvd_pkg::dec_result_t                result,
    output logic                                 advance,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pbvd_pkg::M_TDATA_W-1:0]       m_tdata,  // [60:0] field_number, [92:61] field_value
    output logic [pbvd_pkg::M_TUSER_W-1:0]       m_tuser,  // [2:0] status
    output logic                                 m_tlast   // last
);

    logic                  valid_reg;
    pbvd_pkg::dec_result_t result_reg;

    assign advance = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load && res_valid) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(pbvd_pkg::M_TDATA_W-pbvd_pkg::FIELD_W-pbvd_pkg::VALUE_W){1'b0}},
                       result_reg.field_value, result_reg.field_number};
    assign m_tuser  = result_reg.status;
    assign m_tlast  = result_reg.last;

endmodule

`default_nettype wire

// File: sv/protobuf_varint_field_decoder.sv
// top level of the protobuf varint field decoder
// an input byte is registered in the input stage and its result in the output stage register
// throughput: one byte per cycle unless m_tready stalls the output stage, set by the single-pass
// decode of a byte against the element state registers between the input and result registers
// reset: synchronous active-low aresetn empties both stages and returns the
// decoder to expecting a key with a cleared accumulator
`default_nettype none

module protobuf_varint_field_decoder #(
    parameter int MAX_VARINT_BYTES = pbvd_pkg::DEFAULT_MAX_VARINT_BYTES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pbvd_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                           s_tlast,  // end_of_message
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pbvd_pkg::M_TDATA_W-1:0]      m_tdata,  // [60:0] field_number, [92:61] field_value
    output logic [pbvd_pkg::M_TUSER_W-1:0]      m_tuser,  // [2:0] status
    output logic                                m_tlast   // last
);

    pbvd_pkg::in_item_t    item;
    pbvd_pkg::dec_state_t  state_reg;
    pbvd_pkg::dec_state_t  state_next;
    pbvd_pkg::dec_result_t result;
    logic                  res_valid;
    logic                  advance;
    logic                  load;

    assign load = item.valid && advance;

    pbvd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .item     (item)
    );

    pbvd_step #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_step (
        .state      (state_reg),
        .data_byte  (item.data_byte),
        .last       (item.last),
        .state_next (state_next),
        .res_valid  (res_valid),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= pbvd_pkg::PH_KEY;
            state_reg.acc   <= '0;
            state_reg.cnt   <= '0;
            state_reg.held  <= '0;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    pbvd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .res_valid (res_valid),
        .result    (result),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: test/tb_protobuf_varint_field_decoder.sv
// testbench for the protobuf varint field decoder: byte stimulus, cycle-free prediction, result check
`timescale 1ns / 100ps

module tb_protobuf_varint_field_decoder;

    localparam int MAX_GROUPS  = pbvd_pkg::DEFAULT_MAX_VARINT_BYTES;
    localparam int HOLD_CYCLES = 300;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [pbvd_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [pbvd_pkg::M_TDATA_W-1:0] m_tdata;
    logic [pbvd_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tlast;

    protobuf_varint_field_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // decoder state as predicted
    pbvd_pkg::phase_t             dec_phase;
    logic [pbvd_pkg::ACC_W-1:0]   dec_acc;
    logic [pbvd_pkg::CNT_W-1:0]   dec_groups;
    logic [pbvd_pkg::FIELD_W-1:0] dec_held;

    pbvd_pkg::dec_result_t        expected_fields[$];
    logic [7:0]                   msg_bytes[$];
    int                           mismatch_count;
    int                           bytes_sent;
    bit                           src_idle_en;
    bit                           sink_idle_en;
    bit                           hold_request;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic push_field(input logic [pbvd_pkg::FIELD_W-1:0] fnum,
                              input logic [pbvd_pkg::VALUE_W-1:0] val,
                              input pbvd_pkg::status_t st, input logic l);
        pbvd_pkg::dec_result_t r;
        r.field_number = fnum;
        r.field_value  = val;
        r.status       = st;
        r.last         = l;
        expected_fields.push_back(r);
    endtask

    task automatic reset_decoder();
        dec_phase  = pbvd_pkg::PH_KEY;
        dec_acc    = '0;
        dec_groups = '0;
        dec_held   = '0;
    endtask

    task automatic flag_error(input pbvd_pkg::status_t st, input logic l);
        push_field('0, '0, st, l);
        dec_acc    = '0;
        dec_groups = '0;
        dec_phase  = l ? pbvd_pkg::PH_KEY : pbvd_pkg::PH_DISCARD;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic l);
        logic [5:0] shift;
        if (dec_phase != pbvd_pkg::PH_VALUE && dec_phase != pbvd_pkg::PH_DISCARD)
            dec_phase = pbvd_pkg::PH_KEY;
        if (dec_phase == pbvd_pkg::PH_DISCARD) begin
            if (l)
                dec_phase = pbvd_pkg::PH_KEY;
        end else begin
            shift      = 6'(7 * dec_groups);
            dec_acc    = dec_acc | ({57'b0, b[6:0]} << shift);
            dec_groups = dec_groups + 1'b1;
            if (dec_groups >= MAX_GROUPS) begin
                flag_error(pbvd_pkg::ST_LONG, l);
            end else if (b[7]) begin
                if (l)
                    flag_error(pbvd_pkg::ST_TRUNC, l);
            end else if (dec_phase == pbvd_pkg::PH_KEY) begin
                if (dec_acc[63:3] == '0)
                    flag_error(pbvd_pkg::ST_FIELD0, l);
                else if (dec_acc[2:0] != pbvd_pkg::WIRE_VARINT)
                    flag_error(pbvd_pkg::ST_WIRETYPE, l);
                else if (l)
                    flag_error(pbvd_pkg::ST_TRUNC, l);
                else begin
                    dec_held   = dec_acc[63:3];
                    dec_acc    = '0;
                    dec_groups = '0;
                    dec_phase  = pbvd_pkg::PH_VALUE;
                end
            end else begin
                push_field(dec_held, dec_acc[31:0], pbvd_pkg::ST_OK, l);
                dec_acc    = '0;
                dec_groups = '0;
                dec_held   = '0;
                dec_phase  = pbvd_pkg::PH_KEY;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, l);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    // encodes v in at least min_len groups, padding with empty continuation groups
    task automatic add_varint(input logic [63:0] v, input int min_len);
        int         n;
        int         total;
        logic [63:0] t;
        logic [7:0] b;
        n = 1;
        t = v >> 7;
        while (t != 0) begin
            n++;
            t = t >> 7;
        end
        total = (min_len > n) ? min_len : n;
        for (int i = 0; i < total; i++) begin
            t       = v >> (7 * i);
            b[6:0]  = t[6:0];
            b[7]    = (i < total - 1);
            msg_bytes.push_back(b);
        end
    endtask

    function automatic logic [pbvd_pkg::FIELD_W-1:0] rand_field();
        int                           r;
        logic [pbvd_pkg::FIELD_W-1:0] f;
        r = $urandom_range(0, 9);
        if (r < 7)
            f = pbvd_pkg::FIELD_W'($urandom_range(1, 31));
        else if (r < 9)
            f = pbvd_pkg::FIELD_W'($urandom_range(1, 65535));
        else begin
            f = pbvd_pkg::FIELD_W'({$urandom, $urandom});
            if (f == '0)
                f = pbvd_pkg::FIELD_W'(1);
        end
        return f;
    endfunction

    function automatic logic [63:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 64'($urandom_range(0, 127));
        else if (r < 6)
            return 64'($urandom_range(0, 16383));
        else if (r < 9)
            return 64'($urandom);
        return {$urandom, $urandom};
    endfunction

    function automatic int pad_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 1;
    endfunction

    task automatic add_element();
        int                           r;
        logic [pbvd_pkg::FIELD_W-1:0] f;
        logic [2:0]                   wt;
        r  = $urandom_range(0, 99);
        f  = rand_field();
        wt = pbvd_pkg::WIRE_VARINT;
        if (r < 5)
            wt = 3'($urandom_range(1, 7));
        else if (r < 9) begin
            f  = '0;
            wt = 3'($urandom_range(0, 7));
        end
        add_varint({f, wt}, (r >= 9 && r < 12) ? MAX_GROUPS : pad_len());
        add_varint(rand_value(), (r >= 12 && r < 15) ? MAX_GROUPS : pad_len());
    endtask

    task automatic send_random_message();
        int n_el;
        int keep;
        n_el = $urandom_range(1, 4);
        repeat (n_el) add_element();
        if ($urandom_range(0, 99) < 8 && msg_bytes.size() > 1) begin
            keep = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
        end
        send_message();
    endtask

    task automatic test_directed();
        // widest field that fits nine groups, value of all ones in the low word
        add_varint({61'h0FFF_FFFF_FFFF_FFFF, 3'b000}, 1);
        add_varint(64'hFFFF_FFFF, 1);
        send_message();
        // field zero on the final byte, recovery at once
        send_byte(8'h07, 1'b1);
        // unsupported wire type, then one discarded byte
        send_byte(8'h0A, 1'b0);
        send_byte(8'hFF, 1'b1);
        // message ends on a continuation byte
        send_byte(8'h80, 1'b1);
        // message ends after a key with no value
        send_byte(8'h08, 1'b1);
        // ten-group varint ending the message, long wins over truncation
        for (int i = 0; i < MAX_GROUPS; i++)
            send_byte(8'hFF, i == MAX_GROUPS - 1);
    endtask

    task automatic test_random_messages(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 15) == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random_message();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_noise(input int n_bytes);
        repeat (n_bytes) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_backpressure(input int n_bytes);
        int target;
        target       = bytes_sent + n_bytes;
        src_idle_en  = 1'b0;
        hold_request = 1'b1;
        while (bytes_sent < target) send_random_message();
        src_idle_en  = 1'b1;
    endtask

    task automatic test_full_rate(input int n_bytes);
        int target;
        target       = bytes_sent + n_bytes;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (bytes_sent < target) send_random_message();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // receiver side
    initial begin
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!sink_idle_en) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : check_result
        pbvd_pkg::dec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[63:0], '0);
            end else begin
                want = expected_fields.pop_front();
                if (m_tdata[pbvd_pkg::FIELD_W-1:0] !== want.field_number)
                    report_mismatch("field_number", 64'(m_tdata[pbvd_pkg::FIELD_W-1:0]),
                                    64'(want.field_number));
                if (m_tdata[pbvd_pkg::FIELD_W+pbvd_pkg::VALUE_W-1:pbvd_pkg::FIELD_W]
                    !== want.field_value)
                    report_mismatch("field_value",
                        64'(m_tdata[pbvd_pkg::FIELD_W+pbvd_pkg::VALUE_W-1:pbvd_pkg::FIELD_W]),
                        64'(want.field_value));
                if (m_tuser[pbvd_pkg::STATUS_W-1:0] !== want.status)
                    report_mismatch("status", 64'(m_tuser[pbvd_pkg::STATUS_W-1:0]),
                                    64'(want.status));
                if (m_tlast !== want.last)
                    report_mismatch("last", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        hold_request   = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        reset_decoder();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_messages(800);
        test_noise(200);
        test_backpressure(150);
        test_full_rate(150);

        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_fields.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: protobuf_varint_field_decoder.f
sv/pbvd_pkg.sv
sv/pbvd_in_stage.sv
sv/pbvd_step.sv
sv/pbvd_out_stage.sv
sv/protobuf_varint_field_decoder.sv
test/tb_protobuf_varint_field_decoder.sv
